FILE: hw/rtl/max_tracking_fifo_macros.svh
// assertion macros used by the max tracking fifo checker
`ifndef MAX_TRACKING_FIFO_MACROS_SVH
`define MAX_TRACKING_FIFO_MACROS_SVH

// same-cycle implication, idle during reset
`define MTF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// next-cycle implication, idle during reset
`define MTF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/mtf_pkg.sv
// types and constants of the max tracking fifo
package mtf_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int VALUE_W     = 31;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_QUERY   = 2'd2
   } op_type;

   // one input item
   typedef struct packed {
      logic [1:0]         operation;
      logic [VALUE_W-1:0] value_in;
   } req_type;

   // one result item
   typedef struct packed {
      logic [VALUE_W-1:0] value_out;
      logic               was_query;
      logic               op_error;
   } rsp_type;

   // per-cell control for one cycle
   typedef struct packed {
      logic shift;   // take contents of the next cell toward the tail
      logic load;    // this cell is the tail slot and takes the new value
      logic raise;   // occupied cell, raise kept max to the new value if smaller
   } cell_ctrl_type;

endpackage

FILE: hw/rtl/mtf_cell.sv
// one storage cell of the max tracking fifo: value and kept maximum
module mtf_cell
   import mtf_pkg::*;
(
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic [VALUE_W-1:0] new_value,
   input  logic [VALUE_W-1:0] next_value,
   input  logic [VALUE_W-1:0] next_max,
   output logic [VALUE_W-1:0] value,
   output logic [VALUE_W-1:0] kept_max
);

   logic [VALUE_W-1:0] value_ff, value_in;
   logic [VALUE_W-1:0] max_ff, max_in;

   // shift toward head, load at tail, or raise kept max
   always_comb begin
      value_in = value_ff;
      max_in   = max_ff;
      priority if (ctrl.shift) begin
         value_in = next_value;
         max_in   = next_max;
      end else if (ctrl.load) begin
         value_in = new_value;
         max_in   = new_value;
      end else if (ctrl.raise && (max_ff < new_value)) begin
         max_in   = new_value;
      end else begin
         // hold contents
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      max_ff   <= max_in;
   end

   assign value    = value_ff;
   assign kept_max = max_ff;

endmodule

FILE: hw/rtl/max_tracking_fifo.sv
// top level of the max tracking fifo: a row of cells with the head at cell zero
//
// channel  direction  handshake             payload
// req      in         start && !busy        req_data (req_type)
// rsp      out        rsp_strobe, 1 cycle   rsp_data (rsp_type)
//
// one item per clock: every cell updates in the same cycle, so busy stays low
// dequeue and query results appear in the cycle after the item is taken
// enqueue gives a result only when the queue is full (error)
// reset is synchronous and clears the fill count and the result strobe
// the receiver cannot stall; each result is shown for exactly one cycle
module max_tracking_fifo
   import mtf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic [COUNT_W-1:0] occ_ff, occ_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               full;
   logic               empty;
   logic               do_enq;
   logic               do_deq;

   cell_ctrl_type      ctrl [QUEUE_DEPTH];
   logic [VALUE_W-1:0] cell_value [QUEUE_DEPTH];
   logic [VALUE_W-1:0] cell_max [QUEUE_DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (occ_ff == COUNT_W'(QUEUE_DEPTH));
   assign empty  = (occ_ff == '0);

   // decode the item, update the fill count, build the result
   always_comb begin
      occ_in        = occ_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      do_enq        = 1'b0;
      do_deq        = 1'b0;
      if (accept) begin
         unique case (req_data.operation)
            OP_ENQUEUE: begin
               if (full) begin
                  rsp_strobe_in        = 1'b1;
                  rsp_data_in.op_error = 1'b1;
               end else begin
                  do_enq = 1'b1;
                  occ_in = occ_ff + COUNT_W'(1);
               end
            end
            OP_DEQUEUE: begin
               rsp_strobe_in = 1'b1;
               if (empty) begin
                  rsp_data_in.op_error = 1'b1;
               end else begin
                  do_deq                = 1'b1;
                  occ_in                = occ_ff - COUNT_W'(1);
                  rsp_data_in.value_out = cell_value[0];
               end
            end
            OP_QUERY: begin
               rsp_strobe_in         = 1'b1;
               rsp_data_in.was_query = 1'b1;
               if (empty) begin
                  rsp_data_in.op_error = 1'b1;
               end else begin
                  rsp_data_in.value_out = cell_max[0];
               end
            end
            default: begin
               // unused code: no effect, no result
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         occ_ff        <= occ_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // row of cells, each fed by its neighbor toward the tail
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [VALUE_W-1:0] nxt_value;
      logic [VALUE_W-1:0] nxt_max;

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign nxt_value = '0;
         assign nxt_max   = '0;
      end else begin : g_mid
         assign nxt_value = cell_value[i+1];
         assign nxt_max   = cell_max[i+1];
      end

      assign ctrl[i].shift = do_deq;
      assign ctrl[i].load  = do_enq && (occ_ff == COUNT_W'(i));
      assign ctrl[i].raise = do_enq && (COUNT_W'(i) < occ_ff);

      mtf_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[i]),
         .new_value  (req_data.value_in),
         .next_value (nxt_value),
         .next_max   (nxt_max),
         .value      (cell_value[i]),
         .kept_max   (cell_max[i])
      );
   end

endmodule

FILE: hw/rtl/mtf_checker.sv
// port-level checks of the max tracking fifo and their binding
`include "max_tracking_fifo_macros.svh"

module mtf_checker
   import mtf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   logic take_query;
   logic take_enq;

   assign take_query = start && !busy && (req_data.operation == OP_QUERY);
   assign take_enq   = start && !busy && (req_data.operation == OP_ENQUEUE);

   // a result only ever follows an accepted item
   `MTF_ASSERT_SAME(a_rsp_follows_item, clock, reset, rsp_strobe, $past(start && !busy))
   // a flagged result carries zero
   `MTF_ASSERT_SAME(a_err_zero, clock, reset, rsp_strobe && rsp_data.op_error, rsp_data.value_out == '0)
   // a query is always answered next cycle and marked as a query
   `MTF_ASSERT_NEXT(a_query_answered, clock, reset, take_query, rsp_strobe && rsp_data.was_query)
   // an enqueue answers only as a full-queue error
   `MTF_ASSERT_NEXT(a_enq_silent, clock, reset, take_enq, !rsp_strobe || (rsp_data.op_error && !rsp_data.was_query))

endmodule

bind max_tracking_fifo mtf_checker u_mtf_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
